/* rtl/pps_pkg.sv */
package pps_pkg;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} in_t;

	typedef struct packed {
		logic        idle;
		logic [3:0]  process_id;
		logic        finished;
		logic [15:0] completion_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic [31:0] total_turnaround;
		logic [31:0] total_waiting;
		logic        all_done;
		logic        error;
	} out_t;

	// one process table row, kept in a single RAM word
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

endpackage

/* rtl/pps_ram.sv */
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/preemptive_priority_scheduler.sv */
// Channel   Ports                 Handshake
// --------  --------------------  ------------------------------------------
// command   start, busy, item     taken at a clock edge with start=1, busy=0
// result    strobe, result        one cycle wide, taken at the edge ending it
//
// Load, clear and the unused command: answered from idle, result in the next cycle,
// busy stays low so a new item can follow right away.
// Tick: busy through the scan, finish and report states (no scan with an empty
// table). The process table sits in one RAM with a registered read port; the scan
// issues one row read per cycle and judges each row when its read data returns,
// then the finish state updates the clock and the chosen row and the report state
// settles waiting time and totals. The result shows in the cycle busy drops.
// Reset (arst_n low) empties the table, the clock and the totals at once.
// The receiver cannot stall; each result is shown for one cycle only.
module preemptive_priority_scheduler #(
	parameter int MAX_PROCESSES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pps_pkg::in_t   item,
	output logic           strobe,
	output pps_pkg::out_t  result
);

	localparam int IW = $clog2(MAX_PROCESSES);
	localparam int CW = $clog2(MAX_PROCESSES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_REPORT
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          fin_cnt_q;
	logic [15:0]            time_q;
	logic [31:0]            tat_sum_q;
	logic [31:0]            wt_sum_q;
	logic [MAX_PROCESSES-1:0] done_q;

	// scan bookkeeping
	logic [CW-1:0]          iss_q;       // next row address to issue
	logic                   rd_valid_q;  // RAM output holds a row to judge
	logic [IW-1:0]          rd_slot_q;   // slot of that row
	logic                   found_q;
	logic [IW-1:0]          best_slot_q;
	pps_pkg::entry_t        best_q;

	// finish bookkeeping
	logic                   fin_q;
	logic [15:0]            tat_q;

	logic                   strobe_q;
	pps_pkg::out_t          result_q;
	logic                   strobe_d;
	pps_pkg::out_t          result_d;

	logic                   accept;
	logic                   full;
	logic [15:0]            burst_clamped;
	pps_pkg::entry_t        load_entry;
	pps_pkg::entry_t        rd_data;
	pps_pkg::entry_t        upd_entry;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	pps_pkg::entry_t        ram_wdata;
	logic [IW-1:0]          ram_raddr;
	logic                   cand_ready;
	logic                   cand_better;
	logic [15:0]            time_next;
	logic [15:0]            rem_dec;
	logic [15:0]            tat_calc;
	logic [15:0]            wt_calc;
	logic [31:0]            tat_sum_next;
	logic [31:0]            wt_sum_next;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	assign full          = (count_q >= CW'(MAX_PROCESSES));
	assign burst_clamped = (item.burst == 16'd0) ? 16'd1 : item.burst;

	always_comb begin
		load_entry.arrival   = item.arrival;
		load_entry.burst     = burst_clamped;
		load_entry.remaining = burst_clamped;
		load_entry.prio      = item.prio;
	end

	// clock advance and one unit of work for the chosen process
	assign time_next = (time_q != pps_pkg::TIME_MAX) ? time_q + 16'd1 : time_q;
	assign rem_dec   = (best_q.remaining != 16'd0) ? best_q.remaining - 16'd1 : 16'd0;
	assign tat_calc  = time_next - best_q.arrival;

	always_comb begin
		upd_entry           = best_q;
		upd_entry.remaining = rem_dec;
	end

	// waiting goes negative only after the clock saturates; clamp at zero
	assign wt_calc      = (tat_q >= best_q.burst) ? tat_q - best_q.burst : 16'd0;
	assign tat_sum_next = tat_sum_q + {16'd0, tat_q};
	assign wt_sum_next  = wt_sum_q + {16'd0, wt_calc};

	// RAM ports: loads and row updates never overlap a scan read
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IW-1:0];
		ram_wdata = load_entry;
		if (state_q == ST_IDLE && accept && item.cmd == pps_pkg::CMD_LOAD && !full) begin
			ram_we = 1'b1;
		end else if (state_q == ST_FINISH && found_q) begin
			ram_we    = 1'b1;
			ram_waddr = best_slot_q;
			ram_wdata = upd_entry;
		end
	end

	assign ram_raddr = iss_q[IW-1:0];

	pps_ram #(
		.WIDTH($bits(pps_pkg::entry_t)),
		.DEPTH(MAX_PROCESSES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// candidate judge: lower priority value wins, then earlier arrival;
	// strict compares keep the lower slot on a full tie
	assign cand_ready = rd_valid_q && !done_q[rd_slot_q] && (rd_data.arrival <= time_q);
	assign cand_better = !found_q ||
		(rd_data.prio < best_q.prio) ||
		((rd_data.prio == best_q.prio) && (rd_data.arrival < best_q.arrival));

	// next result item: short commands answer from ST_IDLE, a tick from ST_REPORT
	always_comb begin
		strobe_d = 1'b0;
		result_d = result_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					result_d                  = '0;
					result_d.total_turnaround = tat_sum_q;
					result_d.total_waiting    = wt_sum_q;
					case (item.cmd)
						pps_pkg::CMD_LOAD: begin
							strobe_d = 1'b1;
							if (full) begin
								result_d.error    = 1'b1;
								result_d.all_done = (fin_cnt_q == count_q);
							end else begin
								result_d.process_id = 4'(count_q[IW-1:0]);
							end
						end
						pps_pkg::CMD_TICK: begin
						end
						pps_pkg::CMD_CLEAR: begin
							strobe_d = 1'b1;
							result_d = '0;
						end
						default: begin
							strobe_d          = 1'b1;
							result_d.all_done = (count_q != '0) && (fin_cnt_q == count_q);
						end
					endcase
				end
			end
			ST_REPORT: begin
				result_d      = '0;
				result_d.idle = !found_q;
				if (found_q) begin
					result_d.process_id = 4'(best_slot_q);
				end
				if (fin_q) begin
					result_d.finished         = 1'b1;
					result_d.completion_time  = time_q;
					result_d.turnaround       = tat_q;
					result_d.waiting          = wt_calc;
					result_d.total_turnaround = tat_sum_next;
					result_d.total_waiting    = wt_sum_next;
				end else begin
					result_d.total_turnaround = tat_sum_q;
					result_d.total_waiting    = wt_sum_q;
				end
				result_d.all_done = (count_q != '0) && (fin_cnt_q == count_q);
				strobe_d          = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			fin_cnt_q   <= '0;
			time_q      <= '0;
			tat_sum_q   <= '0;
			wt_sum_q    <= '0;
			done_q      <= '0;
			iss_q       <= '0;
			rd_valid_q  <= 1'b0;
			rd_slot_q   <= '0;
			found_q     <= 1'b0;
			best_slot_q <= '0;
			best_q      <= '0;
			fin_q       <= 1'b0;
			tat_q       <= '0;
			strobe_q    <= 1'b0;
			result_q    <= '0;
		end else begin
			strobe_q <= strobe_d;
			result_q <= result_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							pps_pkg::CMD_LOAD: begin
								if (!full) begin
									done_q[count_q[IW-1:0]] <= 1'b0;
									count_q                 <= count_q + CW'(1);
								end
							end
							pps_pkg::CMD_TICK: begin
								found_q    <= 1'b0;
								fin_q      <= 1'b0;
								tat_q      <= '0;
								iss_q      <= '0;
								rd_valid_q <= 1'b0;
								state_q    <= (count_q == '0) ? ST_FINISH : ST_SCAN;
							end
							pps_pkg::CMD_CLEAR: begin
								count_q   <= '0;
								fin_cnt_q <= '0;
								time_q    <= '0;
								tat_sum_q <= '0;
								wt_sum_q  <= '0;
								done_q    <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// issue row iss_q while judging the row read last cycle
					if (cand_ready && cand_better) begin
						found_q     <= 1'b1;
						best_slot_q <= rd_slot_q;
						best_q      <= rd_data;
					end
					if (iss_q == count_q) begin
						rd_valid_q <= 1'b0;
						state_q    <= ST_FINISH;
					end else begin
						rd_valid_q <= 1'b1;
						rd_slot_q  <= iss_q[IW-1:0];
						iss_q      <= iss_q + CW'(1);
					end
				end
				ST_FINISH: begin
					time_q <= time_next;
					if (found_q && rem_dec == 16'd0) begin
						done_q[best_slot_q] <= 1'b1;
						fin_cnt_q           <= fin_cnt_q + CW'(1);
						fin_q               <= 1'b1;
						tat_q               <= tat_calc;
					end
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (fin_q) begin
						tat_sum_q <= tat_sum_next;
						wt_sum_q  <= wt_sum_next;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/pps_checker.sv */
module pps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input pps_pkg::in_t  item,
	input logic          strobe,
	input pps_pkg::out_t result
);

	// short commands answer in the very next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.cmd != pps_pkg::CMD_TICK |=> strobe)
		else $error("short command gave no result next cycle");

	// a tick always raises busy and gives no immediate result
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.cmd == pps_pkg::CMD_TICK |=> busy && !strobe)
		else $error("tick did not enter the scan");

	// no result appears out of nowhere
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy) || $past(start && !busy))
		else $error("result without a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(result.idle && result.finished))
		else $error("idle tick reported a finished process");

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.error |-> result.process_id == 4'd0 && !result.finished)
		else $error("refused load carried a slot or completion");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
